/* rtl/pixel_row_metadata_decoder_unit_assert.svh */
// Assertion macros used by the metadata decoder checker.
`ifndef PIXEL_ROW_METADATA_DECODER_UNIT_ASSERT_SVH
`define PIXEL_ROW_METADATA_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pmd_pkg.sv */
// Shared constants and types of the pixel row metadata decoder.
`default_nettype none
package pmd_pkg;

    localparam int ROW_WIDTH     = 3200;
    localparam int SAMPLE_PITCH  = 8;
    localparam int SAMPLE_BITS   = $clog2(SAMPLE_PITCH);
    localparam int SAMPLE_PHASE  = SAMPLE_PITCH / 2;
    localparam int POS_W         = 12;
    localparam int RECORD_BYTES  = 50;

    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(ROW_WIDTH - 1);

    localparam logic [15:0] MAGIC_A = 16'habcd;
    localparam logic [15:0] MAGIC_B = 16'hface;

    // Record layout (byte offsets)
    localparam int MAGIC_A_BASE = 1;
    localparam int FC_BASE      = 3;
    localparam int TS_BASE      = 16;
    localparam int PAIR_BASE    = 24;
    localparam int EXP_BASE     = 28;
    localparam int GAIN_BASE    = 40;
    localparam int MAGIC_B_BASE = 48;

    localparam int NUM_CAMERAS = 5;
    localparam logic [2:0] CAM_MAX = 3'(NUM_CAMERAS - 1);

    // Row offset = (exposure + bias) / 38, via reciprocal multiply
    localparam int SUM_W       = 17;
    localparam int OFFSET_BIAS = 275;
    localparam int DIV_SHIFT   = 24;
    localparam int RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(441506);
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - DIV_SHIFT;

    localparam int ROW_W = 9;
    localparam logic [ROW_W-1:0] ROW_MIN      = ROW_W'(8);
    localparam logic [ROW_W-1:0] ROW_MAX      = ROW_W'(375);
    localparam logic [ROW_W-1:0] CROP_DEFAULT = ROW_W'(40);

    // Configuration
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_SELECT = 2'd1;
    localparam logic [7:0] THRESHOLD_RESET = 8'd128;
    localparam logic [2:0] CAMERA_RESET    = 3'd0;

    // Sampler to byte chain and row-end logic
    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       row_full;
    } sample_t;

    // Record fields captured at the end of a row
    typedef struct packed {
        logic        ok;
        logic [7:0]  ftype;
        logic [15:0] frame_counter;
        logic [31:0] pair_counter;
        logic [63:0] timestamp;
        logic [15:0] exp_sel;
        logic [7:0]  gain;
        logic [15:0] exp0;
    } rec_fields_t;

endpackage
`default_nettype wire

/* rtl/pmd_byte_cell.sv */
// One byte cell of the record shift chain.
`default_nettype none
module pmd_byte_cell (
    input  wire logic       clk,
    input  wire logic       shift_en,
    input  wire logic [7:0] data_in,
    output logic      [7:0] data_out
);
    logic [7:0] data_reg;

    // Advance the chain when a completed byte enters at the tail
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out = data_reg;
endmodule
`default_nettype wire

/* rtl/pmd_sampler.sv */
// Pixel position counter, threshold sampler and bit packer.
`default_nettype none
module pmd_sampler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] pixel,
    input  wire logic       last_pixel,
    input  wire logic [7:0] threshold,
    output pmd_pkg::sample_t sample
);
    import pmd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       acc_reg, acc_next;
    logic             sample_hit;
    logic [2:0]       slot;
    logic [7:0]       acc_new;

    assign slot       = pos_reg[SAMPLE_BITS +: 3];
    assign sample_hit = (pos_reg < POS_W'(ROW_WIDTH)) &&
                        (pos_reg[SAMPLE_BITS-1:0] == SAMPLE_BITS'(SAMPLE_PHASE));

    // MSB first: slot 0 starts a fresh byte
    assign acc_new = ((slot == 3'd0) ? 8'h00 : acc_reg) |
                     ((pixel > threshold) ? (8'h80 >> slot) : 8'h00);

    always_comb
    begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        if (accept)
        begin
            if (sample_hit)
            begin
                acc_next = acc_new;
            end
            if (last_pixel)
            begin
                pos_next = '0;
                acc_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
        end
    end

    assign sample.push     = accept && sample_hit && (slot == 3'd7);
    assign sample.data     = acc_new;
    assign sample.row_full = (pos_reg == POS_LAST);
endmodule
`default_nettype wire

/* rtl/pmd_result_pipe.sv */
// Two-stage result pipeline: capture, reciprocal multiply, clamp.
`default_nettype none
module pmd_result_pipe (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire pmd_pkg::rec_fields_t fields,
    output logic             load_ready,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             frame_ok,
    output logic             slam_frame,
    output logic [7:0]       frame_type_byte,
    output logic [15:0]      frame_counter,
    output logic [31:0]      pair_counter,
    output logic [63:0]      timestamp_us,
    output logic [15:0]      exposure,
    output logic [7:0]       gain,
    output logic [8:0]       camera_row_offset,
    output logic [8:0]       crop_row
);
    import pmd_pkg::*;

    function automatic logic [ROW_W-1:0] row_clamp(input logic [QUOT_W-1:0] q);
        logic [ROW_W-1:0] r;
        if (q > QUOT_W'(ROW_MAX))
            r = ROW_MAX;
        else if (q < QUOT_W'(ROW_MIN))
            r = ROW_MIN;
        else
            r = q[ROW_W-1:0];
        return r;
    endfunction

    logic              s1_valid_reg;
    rec_fields_t       s1_fields_reg;
    logic [SUM_W-1:0]  s1_sum_sel_reg;
    logic [SUM_W-1:0]  s1_sum0_reg;

    logic              s2_valid_reg;
    rec_fields_t       s2_fields_reg;
    logic [PROD_W-1:0] s2_prod_sel_reg;
    logic [PROD_W-1:0] s2_prod0_reg;

    logic s1_free, s2_free;
    logic [ROW_W-1:0] off_sel, off0;

    assign s2_free    = !s2_valid_reg || result_ready;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign load_ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= load;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Drop every field of a rejected row to zero at capture
    always_ff @(posedge clk)
    begin
        if (s1_free && load)
        begin
            s1_fields_reg  <= fields.ok ? fields : '0;
            s1_sum_sel_reg <= fields.ok ?
                              (SUM_W'(fields.exp_sel) + SUM_W'(OFFSET_BIAS)) : '0;
            s1_sum0_reg    <= fields.ok ?
                              (SUM_W'(fields.exp0) + SUM_W'(OFFSET_BIAS)) : '0;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_fields_reg   <= s1_fields_reg;
            s2_prod_sel_reg <= PROD_W'(s1_sum_sel_reg) * PROD_W'(DIV_RECIP);
            s2_prod0_reg    <= PROD_W'(s1_sum0_reg) * PROD_W'(DIV_RECIP);
        end
    end

    assign off_sel = row_clamp(s2_prod_sel_reg[DIV_SHIFT +: QUOT_W]);
    assign off0    = row_clamp(s2_prod0_reg[DIV_SHIFT +: QUOT_W]);

    assign result_valid    = s2_valid_reg;
    assign frame_ok        = s2_fields_reg.ok;
    assign slam_frame      = s2_fields_reg.ftype[7];
    assign frame_type_byte = s2_fields_reg.ftype;
    assign frame_counter   = s2_fields_reg.frame_counter;
    assign pair_counter    = s2_fields_reg.pair_counter;
    assign timestamp_us    = s2_fields_reg.timestamp;
    assign exposure        = s2_fields_reg.exp_sel;
    assign gain            = s2_fields_reg.gain;
    assign camera_row_offset = s2_fields_reg.ok ? off_sel : '0;
    assign crop_row = !s2_fields_reg.ok      ? '0 :
                      s2_fields_reg.ftype[7] ? off0 : CROP_DEFAULT;
endmodule
`default_nettype wire

/* rtl/pixel_row_metadata_decoder_unit.sv */
// Top level of the pixel row metadata decoder.
`default_nettype none
// Decodes the metadata row a camera embeds in its frames. Pixels come in one
// transaction per clock on the pixel channel; every eighth pixel (offset 4 of
// each 8-pixel block) is compared against bit_threshold and the bits are
// packed MSB first into a 50-byte record held in a chain of byte cells, each
// completed byte entering at the tail and moving the others one cell along.
// The transaction marked last_pixel closes the row: the row is good only if it
// was exactly 3200 pixels wide and carries the little-endian magics 0xabcd
// (bytes 1..2) and 0xface (bytes 48..49). One result transaction follows per
// row, with frame type, SLAM flag, counters, timestamp and the exposure, gain
// and row offset of the camera chosen by camera_select (values above 4 select
// camera 4); a bad row reports all fields as zero. Throughput is one pixel per
// clock while pixel_ready is high, set by the sampler's single compare and
// shift; the row offset divide by 38 is a reciprocal multiply in the second
// result stage. Two result stages buffer row ends, so pixel_ready falls only
// when both hold an untaken result and result_ready is low. Configuration
// writes are always taken (cfg_ready is tied high) and belong to idle
// periods; indexes past camera_select are ignored.
module pixel_row_metadata_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [pmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        pixel_valid,
    output logic             pixel_ready,
    input  wire logic [7:0]  pixel,
    input  wire logic        last_pixel,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             frame_ok,
    output logic             slam_frame,
    output logic [7:0]       frame_type_byte,
    output logic [15:0]      frame_counter,
    output logic [31:0]      pair_counter,
    output logic [63:0]      timestamp_us,
    output logic [15:0]      exposure,
    output logic [7:0]       gain,
    output logic [8:0]       camera_row_offset,
    output logic [8:0]       crop_row
);
    import pmd_pkg::*;

    logic [7:0] threshold_reg;
    logic [2:0] camera_reg;
    logic       pixel_accept;
    sample_t    sample;
    logic [2:0] cam_sat;
    rec_fields_t fields;

    logic [7:0] rec_byte [RECORD_BYTES];

    // Configuration registers; the user must make writes land only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            camera_reg    <= CAMERA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BIT_THRESHOLD: threshold_reg <= cfg_data;
                CFG_CAMERA_SELECT: camera_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign pixel_accept = pixel_valid && pixel_ready;

    pmd_sampler u_sampler (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (pixel_accept),
        .pixel      (pixel),
        .last_pixel (last_pixel),
        .threshold  (threshold_reg),
        .sample     (sample)
    );

    // Record chain: byte k of the row sits in cell k once all 50 bytes are in
    for (genvar i = 0; i < RECORD_BYTES; i++)
    begin : g_cell
        logic [7:0] cell_in;
        if (i == RECORD_BYTES - 1)
        begin : g_tail
            assign cell_in = sample.data;
        end
        else
        begin : g_body
            assign cell_in = rec_byte[i+1];
        end
        pmd_byte_cell u_cell (
            .clk      (clk),
            .shift_en (sample.push),
            .data_in  (cell_in),
            .data_out (rec_byte[i])
        );
    end

    // Saturate the camera selector at the last camera
    assign cam_sat = (camera_reg > CAM_MAX) ? CAM_MAX : camera_reg;

    // Gather the record fields seen at the closing pixel
    always_comb
    begin
        fields.ok = sample.row_full &&
                    ({rec_byte[MAGIC_A_BASE+1], rec_byte[MAGIC_A_BASE]} == MAGIC_A) &&
                    ({rec_byte[MAGIC_B_BASE+1], rec_byte[MAGIC_B_BASE]} == MAGIC_B);
        fields.ftype         = rec_byte[0];
        fields.frame_counter = {rec_byte[FC_BASE+1], rec_byte[FC_BASE]};
        for (int k = 0; k < 4; k++)
        begin
            fields.pair_counter[8*k +: 8] = rec_byte[PAIR_BASE+k];
        end
        for (int k = 0; k < 8; k++)
        begin
            fields.timestamp[8*k +: 8] = rec_byte[TS_BASE+k];
        end
        fields.exp0    = {rec_byte[EXP_BASE+1], rec_byte[EXP_BASE]};
        fields.exp_sel = fields.exp0;
        fields.gain    = rec_byte[GAIN_BASE];
        for (int c = 1; c < NUM_CAMERAS; c++)
        begin
            if (cam_sat == 3'(c))
            begin
                fields.exp_sel = {rec_byte[EXP_BASE+2*c+1], rec_byte[EXP_BASE+2*c]};
                fields.gain    = rec_byte[GAIN_BASE+c];
            end
        end
    end

    pmd_result_pipe u_result (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (pixel_accept && last_pixel),
        .fields            (fields),
        .load_ready        (pixel_ready),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .frame_ok          (frame_ok),
        .slam_frame        (slam_frame),
        .frame_type_byte   (frame_type_byte),
        .frame_counter     (frame_counter),
        .pair_counter      (pair_counter),
        .timestamp_us      (timestamp_us),
        .exposure          (exposure),
        .gain              (gain),
        .camera_row_offset (camera_row_offset),
        .crop_row          (crop_row)
    );
endmodule
`default_nettype wire

/* rtl/pmd_checker.sv */
// Port-level checker for the metadata decoder, bound to the top level.
`default_nettype none
`include "pixel_row_metadata_decoder_unit_assert.svh"
module pmd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic        frame_ok,
    input wire logic        slam_frame,
    input wire logic [7:0]  frame_type_byte,
    input wire logic [15:0] exposure,
    input wire logic [7:0]  gain,
    input wire logic [8:0]  camera_row_offset,
    input wire logic [8:0]  crop_row
);
    // Hold a stalled result
    `PMD_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid, "result dropped while stalled")

    // A rejected row reports zeros
    `PMD_ASSERT_NOW(a_bad_row_zero, clk, rst_n, result_valid && !frame_ok, !slam_frame && frame_type_byte == 8'd0 && exposure == 16'd0 && gain == 8'd0 && camera_row_offset == 9'd0 && crop_row == 9'd0, "rejected row carries nonzero fields")

    // Offsets of a good row stay within the clamp range
    `PMD_ASSERT_NOW(a_offset_range, clk, rst_n, result_valid && frame_ok, camera_row_offset >= 9'd8 && camera_row_offset <= 9'd375 && crop_row >= 9'd8 && crop_row <= 9'd375, "row offset out of range")

    // SLAM flag follows the frame type, and the crop row defaults without it
    `PMD_ASSERT_NOW(a_slam_crop, clk, rst_n, result_valid && frame_ok, slam_frame == frame_type_byte[7] && (slam_frame || crop_row == 9'd40), "SLAM flag or crop row mismatch")
endmodule

bind pixel_row_metadata_decoder_unit pmd_checker u_pmd_checker (.*);
`default_nettype wire
